>>> hw/rtl/shm_pkg.sv
// Shared types and constants for the signal health monitor.
// Used by shm_cell and signal_health_monitor; depends on nothing else.
package shm_pkg;

  typedef enum logic [2:0] {
    KIND_TICK      = 3'd0,
    KIND_UPDATE    = 3'd1,
    KIND_RESET_ONE = 3'd2,
    KIND_RESET_ALL = 3'd3,
    KIND_EVALUATE  = 3'd4,
    KIND_QUERY     = 3'd5,
    KIND_LOAD      = 3'd6
  } kind_e;

  typedef enum logic [2:0] {
    LIM_CRIT_TO   = 3'd0,
    LIM_WARN_TO   = 3'd1,
    LIM_CRIT_LOW  = 3'd2,
    LIM_CRIT_HIGH = 3'd3,
    LIM_WARN_LOW  = 3'd4,
    LIM_WARN_HIGH = 3'd5,
    LIM_ENABLE    = 3'd6
  } lim_sel_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_WARN = 2'd1,
    ST_CRIT = 2'd2
  } status_e;

  typedef enum logic {
    CS_IDLE = 1'b0,
    CS_EVAL = 1'b1
  } ctrl_state_e;

  localparam int unsigned DataW = 32;

  // Command broadcast to every cell on a transfer
  typedef struct packed {
    logic                    tick;
    logic                    upd;
    logic                    clr_one;
    logic                    clr_all;
    logic                    load;
    logic [2:0]              lsel;
    logic signed [DataW-1:0] data;
  } cell_cmd_t;

  // What one cell shows for a query
  typedef struct packed {
    logic                    seen;
    status_e                 judge;
    logic signed [DataW-1:0] value;
    logic [DataW-1:0]        age;
  } cell_view_t;

endpackage

>>> hw/rtl/shm_cell.sv
// One monitored signal: sample, age, seen flag, limits and its status judge.
// Passes a registered worst-status token to its neighbor. Depends on shm_pkg.
module shm_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  shm_pkg::cell_cmd_t cmd_i,
  input  logic               hit_i,
  input  logic               active_i,
  input  shm_pkg::status_e   worst_i,
  output shm_pkg::status_e   worst_o,
  output shm_pkg::cell_view_t view_o
);
  import shm_pkg::*;

  logic signed [DataW-1:0] sample_q, sample_d;
  logic [DataW-1:0]        age_q, age_d;
  logic                    seen_q, seen_d;
  logic [DataW-1:0]        crit_to_q, crit_to_d;
  logic [DataW-1:0]        warn_to_q, warn_to_d;
  logic signed [DataW-1:0] crit_lo_q, crit_lo_d;
  logic signed [DataW-1:0] crit_hi_q, crit_hi_d;
  logic signed [DataW-1:0] warn_lo_q, warn_lo_d;
  logic signed [DataW-1:0] warn_hi_q, warn_hi_d;
  logic                    en_q, en_d;
  status_e                 worst_q, worst_d;

  status_e                 to_st, val_st, judge;
  logic [DataW-1:0]        timeout_val;
  logic                    clear;

  // Timeout and range judgement
  always_comb begin
    to_st  = ST_OK;
    val_st = ST_OK;
    if (seen_q) begin
      if (age_q > crit_to_q) begin
        to_st = ST_CRIT;
      end else if (age_q > warn_to_q) begin
        to_st = ST_WARN;
      end
    end else if (crit_to_q != '0) begin
      to_st = ST_CRIT;
    end
    if (en_q) begin
      if (sample_q < crit_lo_q || sample_q > crit_hi_q) begin
        val_st = ST_CRIT;
      end else if (sample_q < warn_lo_q || sample_q > warn_hi_q) begin
        val_st = ST_WARN;
      end
    end
    judge = (to_st > val_st) ? to_st : val_st;
  end

  // Fold own status into the token from the left neighbor
  always_comb begin
    worst_d = worst_i;
    if (active_i && judge > worst_i) begin
      worst_d = judge;
    end
  end

  assign clear       = (cmd_i.clr_one && hit_i) || (cmd_i.clr_all && active_i);
  assign timeout_val = cmd_i.data[DataW-1] ? '0 : cmd_i.data;

  always_comb begin
    sample_d  = sample_q;
    age_d     = age_q;
    seen_d    = seen_q;
    crit_to_d = crit_to_q;
    warn_to_d = warn_to_q;
    crit_lo_d = crit_lo_q;
    crit_hi_d = crit_hi_q;
    warn_lo_d = warn_lo_q;
    warn_hi_d = warn_hi_q;
    en_d      = en_q;
    if (cmd_i.tick && seen_q && age_q != '1) begin
      age_d = age_q + 1'b1;
    end
    if (cmd_i.upd && hit_i) begin
      sample_d = cmd_i.data;
      age_d    = '0;
      seen_d   = 1'b1;
    end
    if (clear) begin
      sample_d = '0;
      age_d    = '0;
      seen_d   = 1'b0;
    end
    if (cmd_i.load && hit_i) begin
      unique case (cmd_i.lsel)
        LIM_CRIT_TO:   crit_to_d = timeout_val;
        LIM_WARN_TO:   warn_to_d = timeout_val;
        LIM_CRIT_LOW:  crit_lo_d = cmd_i.data;
        LIM_CRIT_HIGH: crit_hi_d = cmd_i.data;
        LIM_WARN_LOW:  warn_lo_d = cmd_i.data;
        LIM_WARN_HIGH: warn_hi_d = cmd_i.data;
        LIM_ENABLE:    en_d      = cmd_i.data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_q  <= '0;
      age_q     <= '0;
      seen_q    <= 1'b0;
      crit_to_q <= '0;
      warn_to_q <= '0;
      crit_lo_q <= '0;
      crit_hi_q <= '0;
      warn_lo_q <= '0;
      warn_hi_q <= '0;
      en_q      <= 1'b0;
      worst_q   <= ST_OK;
    end else begin
      sample_q  <= sample_d;
      age_q     <= age_d;
      seen_q    <= seen_d;
      crit_to_q <= crit_to_d;
      warn_to_q <= warn_to_d;
      crit_lo_q <= crit_lo_d;
      crit_hi_q <= crit_hi_d;
      warn_lo_q <= warn_lo_d;
      warn_hi_q <= warn_hi_d;
      en_q      <= en_d;
      worst_q   <= worst_d;
    end
  end

  assign worst_o      = worst_q;
  assign view_o.seen  = seen_q;
  assign view_o.judge = judge;
  assign view_o.value = sample_q;
  assign view_o.age   = age_q;

endmodule

>>> hw/rtl/signal_health_monitor.sv
// Top level of the signal health monitor: control, output register, cell chain.
// Depends on shm_pkg and shm_cell.

// Watchdog with range checks for up to SIGNALS signals, one cell per signal in
// a chain. Every input transfer yields exactly one result transfer. For tick,
// update, reset one, reset all, query and limit load the result is loaded into
// the output register in the cycle the item is taken, and the next item is
// taken in the following cycle as long as the output register has been
// drained. Evaluate-all starts a walk: each cell folds its own status into a
// worst-status token registered at every cell, and the token ripples register
// by register from the first to the last cell of the chain. During that walk
// the input is stalled; the result is loaded once the token has crossed every
// cell and the output register is free. The worst status is latched as the
// overall status, which tick, update, reset one and limit load report; reset
// all clears it to OK. signal_count is written through cfg_we_i / cfg_wdata_i;
// the user writes it only while the block is idle; the block does not enforce
// this. Values above SIGNALS act as SIGNALS. Indices at or above the active
// count are ignored, and a query of one answers critical with never_seen set.
module signal_health_monitor #(
  parameter int unsigned SIGNALS = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [3:0]          cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [2:0]          kind_i,
  input  logic [2:0]          signal_index_i,
  input  logic [2:0]          limit_select_i,
  input  logic signed [31:0]  data_value_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [1:0]          status_o,
  output logic signed [31:0]  signal_value_o,
  output logic [31:0]         age_ms_o,
  output logic                never_seen_o
);
  import shm_pkg::*;

  localparam int unsigned CW = $clog2(SIGNALS + 1);
  localparam int unsigned AW = (CW > 4) ? CW : 4;
  localparam int unsigned EW = (CW > 0) ? CW : 1;

  // Configuration and latched status
  logic [3:0]       sig_count_q;
  status_e          overall_q, overall_d;
  ctrl_state_e      state_q, state_d;
  logic [EW-1:0]    eval_cnt_q, eval_cnt_d;

  // Output register
  logic             out_valid_q, out_valid_d;
  status_e          status_q, status_d;
  logic signed [31:0] value_q, value_d;
  logic [31:0]      age_q, age_d;
  logic             never_q, never_d;

  logic             in_accept, out_ready, out_load, eval_done;
  logic [AW-1:0]    cnt_ext, act_cnt;
  logic             ok_idx;
  cell_cmd_t        cmd;
  logic [SIGNALS-1:0] hit, active;
  status_e          worst [SIGNALS+1];
  cell_view_t       view [SIGNALS];
  cell_view_t       qview;

  // Saturate the count to the number of cells
  assign cnt_ext = AW'(sig_count_q);
  assign act_cnt = (cnt_ext > AW'(SIGNALS)) ? AW'(SIGNALS) : cnt_ext;
  assign ok_idx  = AW'(signal_index_i) < act_cnt;

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != CS_IDLE) || !out_ready;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign eval_done  = eval_cnt_q == EW'(SIGNALS);

  // Broadcast command; only asserted on a transfer
  always_comb begin
    cmd.tick    = in_accept && (kind_i == KIND_TICK);
    cmd.upd     = in_accept && (kind_i == KIND_UPDATE);
    cmd.clr_one = in_accept && (kind_i == KIND_RESET_ONE);
    cmd.clr_all = in_accept && (kind_i == KIND_RESET_ALL);
    cmd.load    = in_accept && (kind_i == KIND_LOAD);
    cmd.lsel    = limit_select_i;
    cmd.data    = data_value_i;
  end

  // Cell chain: head of the token is OK
  assign worst[0] = ST_OK;

  for (genvar g = 0; g < SIGNALS; g++) begin : g_cell
    assign active[g] = AW'(g) < act_cnt;
    assign hit[g]    = ok_idx && (AW'(signal_index_i) == AW'(g));

    shm_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .cmd_i    (cmd),
      .hit_i    (hit[g]),
      .active_i (active[g]),
      .worst_i  (worst[g]),
      .worst_o  (worst[g+1]),
      .view_o   (view[g])
    );
  end

  // Select the addressed cell for a query
  always_comb begin
    qview = '0;
    for (int i = 0; i < SIGNALS; i++) begin
      if (hit[i]) begin
        qview = qview | view[i];
      end
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      CS_IDLE: begin
        if (in_accept && kind_i == KIND_EVALUATE) begin
          state_d = CS_EVAL;
        end
      end
      CS_EVAL: begin
        if (eval_done && out_ready) begin
          state_d = CS_IDLE;
        end
      end
      default: state_d = CS_IDLE;
    endcase
  end

  // Outputs of the control: result, latched status, walk counter
  always_comb begin
    out_load   = 1'b0;
    overall_d  = overall_q;
    eval_cnt_d = eval_cnt_q;
    status_d   = overall_q;
    value_d    = '0;
    age_d      = '0;
    never_d    = 1'b0;
    unique case (state_q)
      CS_IDLE: begin
        eval_cnt_d = '0;
        if (in_accept && kind_i != KIND_EVALUATE) begin
          out_load = 1'b1;
          if (kind_i == KIND_RESET_ALL) begin
            overall_d = ST_OK;
            status_d  = ST_OK;
          end else if (kind_i == KIND_QUERY) begin
            if (ok_idx) begin
              status_d = qview.judge;
              value_d  = qview.value;
              age_d    = qview.seen ? qview.age : '0;
              never_d  = !qview.seen;
            end else begin
              status_d = ST_CRIT;
              never_d  = 1'b1;
            end
          end
        end
      end
      CS_EVAL: begin
        // Advance until the token has crossed every cell, then hold
        if (!eval_done) begin
          eval_cnt_d = eval_cnt_q + 1'b1;
        end else if (out_ready) begin
          out_load  = 1'b1;
          overall_d = worst[SIGNALS];
          status_d  = worst[SIGNALS];
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else begin
      out_valid_d = out_valid_q && out_stall_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sig_count_q <= '0;
      overall_q   <= ST_OK;
      state_q     <= CS_IDLE;
      eval_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        sig_count_q <= cfg_wdata_i;
      end
      overall_q   <= overall_d;
      state_q     <= state_d;
      eval_cnt_q  <= eval_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload; hold while stalled
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      status_q <= status_d;
      value_q  <= value_d;
      age_q    <= age_d;
      never_q  <= never_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign signal_value_o = value_q;
  assign age_ms_o       = age_q;
  assign never_seen_o   = never_q;

  // An evaluate transfer starts the chain walk
  a_eval_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && kind_i == KIND_EVALUATE) |=> (state_q == CS_EVAL))
    else $error("evaluate did not start the chain walk");

  // The end of a walk delivers the latched worst status
  a_eval_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == CS_EVAL && eval_done && out_ready)
      |=> (out_valid_o && status_o == overall_q && !never_seen_o))
    else $error("evaluate result does not match latched status");

  // An out-of-range query reads back critical and never seen
  a_bad_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && kind_i == KIND_QUERY && !ok_idx)
      |=> (out_valid_o && never_seen_o && status_o == ST_CRIT && age_ms_o == '0))
    else $error("out-of-range query answered wrongly");

  // No result is loaded while the walk is still running
  a_walk_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == CS_EVAL && !eval_done) |=> !out_load || state_q == CS_EVAL)
    else $error("result loaded before the walk finished");

endmodule
